/* hdl/dsg2d_pkg.sv */
// Shared types, sizes and codes for the 2-D direct-sum gravity block.
package dsg2d_pkg;

  localparam int MAX_BODIES = 1024;
  localparam int AW         = $clog2(MAX_BODIES);
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);

  // pair datapath widths
  localparam int R2_W       = 50;
  localparam int DEN_W      = 82;
  localparam int NUM_W      = 95;
  localparam int ACC_W      = NUM_W + AW + 1;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = NUM_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_BAD_INDEX = 1'b1;

  localparam logic CFG_SOFTENING_SQ = 1'b0;
  localparam logic CFG_BODY_COUNT   = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [9:0]         index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        mass;
  } in_word_t;

  typedef struct packed {
    logic [9:0]         body_index;
    logic signed [63:0] accel_x;
    logic signed [63:0] accel_y;
    logic               status;
  } out_word_t;

endpackage

/* hdl/direct_sum_gravity_2d.sv */
// Top level: softened all-pairs 2-D gravity over a body memory.
//
// Input channel (in_valid / in_stall / in_data) takes load and query words.
// A load writes x, y and mass into one slot of a 96-bit body RAM and gives no
// result. A query walks every slot below the body count through one shared
// 32x32 multiplier, a bit-serial square root (32 steps) and two bit-serial
// dividers (95 steps), and gives one result word.
// Per summed body the walk goes through RAM read, difference, four multiplies,
// r squared, root, the denominator (low product, high product, sum), divide
// and accumulate; the self slot and pairs with zero r squared are not summed.
// A query whose index is not below the count goes straight to the done state
// and answers with error status.
// One item is worked at a time: in_stall is high while a query runs.
// The result sits in an output register; when out_stall holds it, the next
// item is still taken, and a finished query waits for the register to free.
// Reset (rst_n low, synchronous) clears both registers and the handshake;
// body slots hold nothing defined until loaded.
// Config (cfg_we, cfg_index, cfg_data) writes softening_sq or body_count.
module direct_sum_gravity_2d (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dsg2d_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dsg2d_pkg::out_word_t out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SELF, S_RD, S_DIFF, S_MXX, S_MYY, S_MMX, S_MMY,
    S_R2, S_SQRT, S_DLO, S_DHI, S_DEN, S_DIV, S_ACC, S_DONE
  } state_t;

  state_t state_r;

  logic [31:0] soft_r;
  logic [10:0] count_r;
  logic [dsg2d_pkg::CNT_W-1:0] count_eff;

  logic        out_valid_r;
  dsg2d_pkg::out_word_t out_data_r;

  logic [9:0]  idx_r;
  logic        bad_r;
  logic [dsg2d_pkg::CNT_W-1:0] j_r;
  logic [31:0] xi_r, yi_r;
  logic [31:0] adx_r, ady_r, mass_r;
  logic        negx_r, negy_r;
  logic [63:0] sqx_r, sqy_r, px_r, py_r, dlo_r, dhi_r;
  logic [dsg2d_pkg::R2_W-1:0]  r2_r;
  logic [63:0] sq_v_r, sq_res_r, sq_bit_r;
  logic [dsg2d_pkg::DEN_W-1:0] den_r;
  logic [dsg2d_pkg::NUM_W-1:0] nx_r, ny_r;
  logic [dsg2d_pkg::DEN_W-1:0] remx_r, remy_r;
  logic [dsg2d_pkg::STEP_W-1:0] step_r;
  logic signed [dsg2d_pkg::ACC_W-1:0] accx_r, accy_r;

  // body RAM
  logic        ram_we, ram_re;
  logic [dsg2d_pkg::AW-1:0] ram_waddr, ram_raddr;
  logic [95:0] ram_wdata, ram_rdata;

  logic in_fire, q_bad;

  assign count_eff = (32'(count_r) > 32'(dsg2d_pkg::MAX_BODIES)) ?
                     dsg2d_pkg::CNT_W'(dsg2d_pkg::MAX_BODIES) :
                     dsg2d_pkg::CNT_W'(count_r);

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign q_bad     = !(32'(in_data.index) < 32'(count_eff));

  assign ram_we    = in_fire && (in_data.operation == dsg2d_pkg::OP_LOAD) &&
                     (32'(in_data.index) < 32'(dsg2d_pkg::MAX_BODIES));
  assign ram_waddr = dsg2d_pkg::AW'(in_data.index);
  assign ram_wdata = {in_data.mass, in_data.pos_y, in_data.pos_x};

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = dsg2d_pkg::AW'(in_data.index);
    if (state_r == S_IDLE) begin
      ram_re = in_fire && (in_data.operation == dsg2d_pkg::OP_QUERY);
    end else if (state_r == S_RD) begin
      ram_re    = 1'b1;
      ram_raddr = j_r[dsg2d_pkg::AW-1:0];
    end
  end

  dsg2d_ram #(
    .WIDTH (96),
    .DEPTH (dsg2d_pkg::MAX_BODIES)
  ) u_body_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // differences against the queried body
  logic [32:0] dx, dy;
  assign dx = {ram_rdata[31], ram_rdata[31:0]} - {xi_r[31], xi_r};
  assign dy = {ram_rdata[63], ram_rdata[63:32]} - {yi_r[31], yi_r};

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    case (state_r)
      S_MXX:   begin mul_a = adx_r;  mul_b = adx_r; end
      S_MYY:   begin mul_a = ady_r;  mul_b = ady_r; end
      S_MMX:   begin mul_a = mass_r; mul_b = adx_r; end
      S_MMY:   begin mul_a = mass_r; mul_b = ady_r; end
      S_DLO:   begin mul_a = r2_r[31:0]; mul_b = sq_res_r[31:0]; end
      S_DHI:   begin
        mul_a = 32'(r2_r[dsg2d_pkg::R2_W-1:32]);
        mul_b = sq_res_r[31:0];
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  logic [dsg2d_pkg::R2_W-1:0] r2_nxt;
  assign r2_nxt = dsg2d_pkg::R2_W'(sqx_r >> 16) + dsg2d_pkg::R2_W'(sqy_r >> 16) +
                  dsg2d_pkg::R2_W'(soft_r);

  // one step of the integer square root
  logic [63:0] sq_sum, sq_v_nxt, sq_res_nxt;
  always_comb begin
    sq_sum = sq_res_r + sq_bit_r;
    if (sq_v_r >= sq_sum) begin
      sq_v_nxt   = sq_v_r - sq_sum;
      sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
    end else begin
      sq_v_nxt   = sq_v_r;
      sq_res_nxt = sq_res_r >> 1;
    end
  end

  logic [dsg2d_pkg::DEN_W-1:0] den_nxt;
  assign den_nxt = dsg2d_pkg::DEN_W'(dlo_r) + dsg2d_pkg::DEN_W'({dhi_r, 32'b0});

  // one step of each restoring divider; quotient bits shift in behind the dividend
  logic [dsg2d_pkg::DEN_W:0] remx_sh, remy_sh, remx_nxt, remy_nxt;
  logic gex, gey;
  always_comb begin
    remx_sh  = {remx_r, nx_r[dsg2d_pkg::NUM_W-1]};
    remy_sh  = {remy_r, ny_r[dsg2d_pkg::NUM_W-1]};
    gex      = remx_sh >= {1'b0, den_r};
    gey      = remy_sh >= {1'b0, den_r};
    remx_nxt = gex ? remx_sh - {1'b0, den_r} : remx_sh;
    remy_nxt = gey ? remy_sh - {1'b0, den_r} : remy_sh;
  end

  logic signed [dsg2d_pkg::ACC_W-1:0] tx, ty;
  assign tx = $signed(dsg2d_pkg::ACC_W'(nx_r));
  assign ty = $signed(dsg2d_pkg::ACC_W'(ny_r));

  function automatic logic [63:0] sat64(input logic signed [dsg2d_pkg::ACC_W-1:0] a);
    logic [dsg2d_pkg::ACC_W-64:0] top;
    top = a[dsg2d_pkg::ACC_W-1:63];
    if ((top == '0) || (top == '1)) begin
      sat64 = a[63:0];
    end else if (a[dsg2d_pkg::ACC_W-1]) begin
      sat64 = 64'h8000_0000_0000_0000;
    end else begin
      sat64 = 64'h7FFF_FFFF_FFFF_FFFF;
    end
  endfunction

  logic done_fire;
  assign done_fire = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      soft_r      <= '0;
      count_r     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == dsg2d_pkg::CFG_SOFTENING_SQ) begin
          soft_r <= cfg_data;
        end else begin
          count_r <= cfg_data[10:0];
        end
      end

      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && (in_data.operation == dsg2d_pkg::OP_QUERY)) begin
            idx_r  <= in_data.index;
            bad_r  <= q_bad;
            accx_r <= '0;
            accy_r <= '0;
            state_r <= q_bad ? S_DONE : S_SELF;
          end
        end
        S_SELF: begin
          xi_r    <= ram_rdata[31:0];
          yi_r    <= ram_rdata[63:32];
          j_r     <= '0;
          state_r <= S_RD;
        end
        S_RD: begin
          if (j_r == count_eff) begin
            state_r <= S_DONE;
          end else if (32'(j_r) == 32'(idx_r)) begin
            j_r <= j_r + 1'b1;
          end else begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          negx_r  <= dx[32];
          negy_r  <= dy[32];
          adx_r   <= dx[32] ? 32'(-dx) : dx[31:0];
          ady_r   <= dy[32] ? 32'(-dy) : dy[31:0];
          mass_r  <= ram_rdata[95:64];
          state_r <= S_MXX;
        end
        S_MXX: begin sqx_r <= prod; state_r <= S_MYY; end
        S_MYY: begin sqy_r <= prod; state_r <= S_MMX; end
        S_MMX: begin px_r  <= prod; state_r <= S_MMY; end
        S_MMY: begin py_r  <= prod; state_r <= S_R2;  end
        S_R2: begin
          r2_r     <= r2_nxt;
          sq_v_r   <= {r2_nxt, 14'b0};
          sq_res_r <= '0;
          sq_bit_r <= 64'h4000_0000_0000_0000;
          step_r   <= '0;
          if (r2_nxt == '0) begin
            j_r     <= j_r + 1'b1;
            state_r <= S_RD;
          end else begin
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_v_r   <= sq_v_nxt;
          sq_res_r <= sq_res_nxt;
          sq_bit_r <= sq_bit_r >> 2;
          step_r   <= step_r + 1'b1;
          if (step_r == dsg2d_pkg::STEP_W'(dsg2d_pkg::SQRT_STEPS - 1)) begin
            state_r <= S_DLO;
          end
        end
        S_DLO: begin dlo_r <= prod; state_r <= S_DHI; end
        S_DHI: begin dhi_r <= prod; state_r <= S_DEN; end
        S_DEN: begin
          den_r   <= den_nxt;
          nx_r    <= {px_r, 31'b0};
          ny_r    <= {py_r, 31'b0};
          remx_r  <= '0;
          remy_r  <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          remx_r <= remx_nxt[dsg2d_pkg::DEN_W-1:0];
          remy_r <= remy_nxt[dsg2d_pkg::DEN_W-1:0];
          nx_r   <= {nx_r[dsg2d_pkg::NUM_W-2:0], gex};
          ny_r   <= {ny_r[dsg2d_pkg::NUM_W-2:0], gey};
          step_r <= step_r + 1'b1;
          if (step_r == dsg2d_pkg::STEP_W'(dsg2d_pkg::DIV_STEPS - 1)) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          accx_r  <= negx_r ? accx_r - tx : accx_r + tx;
          accy_r  <= negy_r ? accy_r - ty : accy_r + ty;
          j_r     <= j_r + 1'b1;
          state_r <= S_RD;
        end
        S_DONE: begin
          if (done_fire) begin
            out_data_r.body_index <= idx_r;
            out_data_r.accel_x    <= sat64(accx_r);
            out_data_r.accel_y    <= sat64(accy_r);
            out_data_r.status     <= bad_r ? dsg2d_pkg::ST_BAD_INDEX : dsg2d_pkg::ST_OK;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a new word appears only from a finished query
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result word without finished query");

  // an error result carries zero acceleration
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == dsg2d_pkg::ST_BAD_INDEX) |->
      (out_data_r.accel_x == '0) && (out_data_r.accel_y == '0))
    else $error("error result with nonzero acceleration");

  // the walk never passes the body count
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) && (state_r != S_SELF) && (state_r != S_DONE) && !bad_r |->
      32'(j_r) <= 32'(count_eff))
    else $error("body walk beyond count");

endmodule

/* hdl/dsg2d_ram.sv */
// Generic single-port-write, registered-read RAM.
module dsg2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
